>>> rtl/core/range_based_source_switch_assert.svh
// ----------------------------------------------------------------------------
// Range-based source switch assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef RANGE_BASED_SOURCE_SWITCH_ASSERT_SVH
`define RANGE_BASED_SOURCE_SWITCH_ASSERT_SVH

// implication in the same cycle, off during reset
`define RBSS_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// implication in the next cycle, always checked
`define RBSS_ASSERT_NEXT(label, clk_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rbss_pkg.sv
// ----------------------------------------------------------------------------
// rbss_pkg
// Constants shared by the range-based source switch.
// ----------------------------------------------------------------------------
`default_nettype none

package rbss_pkg;

  localparam int DIST_W = 16;
  localparam int LOST_W = 16;
  localparam int HOLD_W = 10;
  localparam int WGT_W  = 9;

  localparam logic [HOLD_W-1:0] HOLD_MAX = 10'd1023;
  localparam logic [WGT_W-1:0]  Q8_ONE   = 9'd256;

  // lost_frames toggle period 200 = 8 * 25; the multiple-of-25 test on
  // lost_frames[15:3] uses q = (x * LOST_RECIP) >> LOST_SHIFT, exact for 13 bits
  localparam int          LOST_SHIFT = 18;
  localparam logic [13:0] LOST_RECIP = 14'd10486;
  localparam logic [4:0]  LOST_ODD   = 5'd25;

  // register indexes
  localparam logic [1:0] REG_SHORT_THR  = 2'd0;
  localparam logic [1:0] REG_LONG_THR   = 2'd1;
  localparam logic [1:0] REG_WEIGHT     = 2'd2;
  localparam logic [1:0] REG_HOLD_LIMIT = 2'd3;

  localparam logic [15:0] SHORT_THR_RST  = 16'd2000;
  localparam logic [15:0] LONG_THR_RST   = 16'd4000;
  localparam logic [8:0]  WEIGHT_RST     = 9'd26;
  localparam logic [9:0]  HOLD_LIMIT_RST = 10'd300;

endpackage

`default_nettype wire

>>> rtl/core/range_based_source_switch.sv
// ----------------------------------------------------------------------------
// range_based_source_switch
// Per-frame near/far source selection from a smoothed target distance.
// ----------------------------------------------------------------------------
// One item per frame enters an input register and is resolved from there
// into the result register, so the block takes one item every cycle while
// the result is not stalled; the rate is set by the update of the smoothed
// distance and hold counter, which each item reads as left by the item
// before it. in_stall rises only when both the input and the result
// register are full and the result is stalled. The user must write the
// registers through the APB port while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module range_based_source_switch
  import rbss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input items
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] measured_distance,
  input  wire logic [15:0] lost_frames,
  input  wire logic        current_mode,
  // result items
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             next_mode,
  output logic             mode_changed,
  output logic [15:0]      filtered_distance,
  output logic [9:0]       frames_since_change,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // configuration registers
  logic [DIST_W-1:0] short_thr;
  logic [DIST_W-1:0] long_thr;
  logic [WGT_W-1:0]  weight;
  logic [HOLD_W-1:0] hold_limit;
  logic              cfg_wr;
  logic [1:0]        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      short_thr  <= SHORT_THR_RST;
      long_thr   <= LONG_THR_RST;
      weight     <= WEIGHT_RST;
      hold_limit <= HOLD_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SHORT_THR:  short_thr  <= pwdata[DIST_W-1:0];
        REG_LONG_THR:   long_thr   <= pwdata[DIST_W-1:0];
        REG_WEIGHT:     weight     <= pwdata[WGT_W-1:0];
        REG_HOLD_LIMIT: hold_limit <= pwdata[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SHORT_THR:  prdata = {16'd0, short_thr};
      REG_LONG_THR:   prdata = {16'd0, long_thr};
      REG_WEIGHT:     prdata = {23'd0, weight};
      REG_HOLD_LIMIT: prdata = {22'd0, hold_limit};
      default:        prdata = 32'd0;
    endcase
  end

  // flow control
  logic s1_valid;
  logic out_free;
  logic s1_fire;
  logic in_fire;

  assign out_free = ~out_valid | ~out_stall;
  assign in_stall = s1_valid & ~out_free;
  assign in_fire  = in_valid & ~in_stall;
  assign s1_fire  = s1_valid & out_free;

  // input register; quotient estimate for the multiple-of-25 test rides along
  logic [DIST_W-1:0] s1_meas;
  logic [LOST_W-1:0] s1_lost;
  logic              s1_cur;
  logic [8:0]        s1_lost_q;
  logic [26:0]       lost_prod;

  assign lost_prod = {14'd0, lost_frames[15:3]} * {13'd0, LOST_RECIP};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_meas   <= measured_distance;
      s1_lost   <= lost_frames;
      s1_cur    <= current_mode;
      s1_lost_q <= lost_prod[LOST_SHIFT+8:LOST_SHIFT];
    end
  end

  // state
  logic [DIST_W-1:0] smoothed;
  logic [DIST_W-1:0] smoothed_next;
  logic [HOLD_W-1:0] hold_count;
  logic [HOLD_W-1:0] hold_count_next;

  // blend: old*256 + (new - old)*w + 128, then >> 8
  logic [WGT_W-1:0]   wq;
  logic signed [16:0] diff;
  logic signed [26:0] blend_prod;
  logic signed [27:0] blend_acc;
  logic [DIST_W-1:0]  blended;

  assign wq         = weight[8] ? Q8_ONE : weight;
  assign diff       = $signed({1'b0, s1_meas}) - $signed({1'b0, smoothed});
  assign blend_prod = diff * $signed({1'b0, wq});
  assign blend_acc  = $signed({4'd0, smoothed, 8'd0}) + 28'(blend_prod) + 28'sd128;
  assign blended    = blend_acc[23:8];

  // lost-target toggle on nonzero multiples of 200
  logic [13:0] q_times_25;
  logic        lost_hit;

  assign q_times_25 = {5'd0, s1_lost_q} * {9'd0, LOST_ODD};
  assign lost_hit   = (s1_lost != '0) && (s1_lost[2:0] == 3'd0)
                      && (q_times_25[12:0] == s1_lost[15:3]) && !q_times_25[13];

  logic              proposed;
  logic [HOLD_W-1:0] hold_inc;
  logic              take;
  logic              mode_sel;

  always_comb begin
    proposed      = s1_cur;
    smoothed_next = smoothed;
    if (s1_meas == '0) begin
      smoothed_next = '0;
      if (lost_hit) begin
        proposed = ~s1_cur;
      end
    end else begin
      smoothed_next = (smoothed == '0) ? s1_meas : blended;
      if (!s1_cur && (smoothed_next > long_thr)) begin
        proposed = 1'b1;
      end else if (s1_cur && (smoothed_next < short_thr)) begin
        proposed = 1'b0;
      end
    end
    hold_inc        = (hold_count == HOLD_MAX) ? hold_count : hold_count + 1'b1;
    take            = (proposed != s1_cur) && (hold_inc > hold_limit);
    hold_count_next = take ? '0 : hold_inc;
    mode_sel        = take ? proposed : s1_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothed   <= '0;
      hold_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (s1_fire) begin
        smoothed   <= smoothed_next;
        hold_count <= hold_count_next;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      next_mode           <= mode_sel;
      mode_changed        <= take;
      filtered_distance   <= smoothed_next;
      frames_since_change <= hold_count_next;
    end
  end

`include "range_based_source_switch_assert.svh"

  `RBSS_ASSERT_SAME(a_change_clears_hold, clk, rst, out_valid && mode_changed,
                    frames_since_change == '0, "mode change without hold reset")
  `RBSS_ASSERT_SAME(a_stall_only_when_full, clk, rst, in_stall,
                    s1_valid && out_valid && out_stall, "input stalled with room downstream")
  `RBSS_ASSERT_NEXT(a_reset_empty, clk, rst, !out_valid && !s1_valid,
                    "pipeline not empty after reset")
  `RBSS_ASSERT_SAME(a_lost_clears_avg, clk, rst, s1_fire && (s1_meas == '0),
                    smoothed_next == '0, "lost target kept average")

endmodule

`default_nettype wire
